>>> hdl/pattr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pattr_pkg
// Shared types and constants for the pinch and triple-tap recognizer.
// ----------------------------------------------------------------------------
package pattr_pkg;

    localparam int OPER_W     = 16;
    localparam int SPAN_W     = 21;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_PINCH_THR   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PINCH_CD    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_MAX     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INTER_TAP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIPLE_CD   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_MOVE    = 3'd5;

    localparam logic [CFG_DATA_W-1:0] RST_PINCH_THR  = 16'd40;
    localparam logic [CFG_DATA_W-1:0] RST_PINCH_CD   = 16'd600;
    localparam logic [CFG_DATA_W-1:0] RST_TAP_MAX    = 16'd400;
    localparam logic [CFG_DATA_W-1:0] RST_INTER_TAP  = 16'd600;
    localparam logic [CFG_DATA_W-1:0] RST_TRIPLE_CD  = 16'd700;
    localparam logic [CFG_DATA_W-1:0] RST_TAP_MOVE   = 16'd40;

    localparam logic [1:0] TAPS_FOR_TOGGLE = 2'd3;

    localparam logic signed [1:0] ZOOM_NONE = 2'sb00;
    localparam logic signed [1:0] ZOOM_IN   = 2'sb01;
    localparam logic signed [1:0] ZOOM_OUT  = 2'sb11;

    typedef struct packed {
        logic        frame_ok;
        logic        new_data;
        logic [3:0]  touch_count;
        logic [15:0] first_x;
        logic [15:0] first_y;
        logic [15:0] second_x;
        logic [15:0] second_y;
        logic [31:0] now_ms;
    } t_in_item;

    typedef struct packed {
        logic signed [1:0] zoom_step;
        logic              mode_toggle;
    } t_out_item;

endpackage : pattr_pkg
`default_nettype wire

>>> hdl/pinch_and_triple_tap_recognizer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pinch_and_triple_tap_recognizer
// Pinch-zoom and triple-tap recognizer over decoded touch frames.
// Two-finger frames pass decide, squaring and the bit-serial square root;
//   released-finger tap checks pass decide, squaring and the tap compare;
//   other frames go from decide to push. One frame in flight at a time.
// Reset: synchronous active-low, restores registers and tracking state,
//   no clearing pass.
// ----------------------------------------------------------------------------
module pinch_and_triple_tap_recognizer #(
    parameter int COORD_BITS     = 16,
    parameter int SPAN_FRAC_BITS = 4,
    parameter int TIME_BITS      = 32
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire pattr_pkg::t_in_item               i_in_data,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output pattr_pkg::t_out_item                   o_out_data,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [pattr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [pattr_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import pattr_pkg::*;

    localparam int ACC_W  = 2 * OPER_W + 1;
    localparam int RAD_W  = 2 * COORD_BITS + 1 + 2 * SPAN_FRAC_BITS;
    localparam int ROOT_W = (RAD_W + 1) / 2;
    localparam int EXT_W  = ROOT_W + SPAN_W;
    localparam int THR_W  = CFG_DATA_W + SPAN_FRAC_BITS;
    localparam int CMP_W  = (SPAN_W > THR_W) ? SPAN_W : THR_W;

    typedef enum logic [3:0] {
        S_IDLE, S_DECIDE, S_SQ_A, S_SQ_B, S_SQ_C, S_SQ_D,
        S_ROOT_GO, S_ROOT, S_PINCH, S_TAP, S_PUSH
    } t_state;

    t_state r_state, n_state;

    logic [CFG_DATA_W-1:0] r_thr, r_zoom_cd, r_tap_max, r_gap_max, r_tri_cd, r_move;

    logic                  r_ok, r_fresh;
    logic [3:0]            r_cnt;
    logic [COORD_BITS-1:0] r_x0, r_y0, r_x1, r_y1;
    logic [TIME_BITS-1:0]  r_now;

    logic                  r_pinch_active, n_pinch_active;
    logic [SPAN_W-1:0]     r_prior_span, n_prior_span;
    logic [TIME_BITS-1:0]  r_zoom_time, n_zoom_time;
    logic                  r_finger_down, n_finger_down;
    logic [TIME_BITS-1:0]  r_down_time, n_down_time;
    logic [COORD_BITS-1:0] r_down_x, n_down_x, r_down_y, n_down_y;
    logic [COORD_BITS-1:0] r_recent_x, n_recent_x, r_recent_y, n_recent_y;
    logic [1:0]            r_tap_tally, n_tap_tally;
    logic [TIME_BITS-1:0]  r_tap_time, n_tap_time;
    logic [TIME_BITS-1:0]  r_triple_time, n_triple_time;

    logic                  r_pinch_path, n_pinch_path;
    logic [ACC_W-1:0]      r_acc, n_acc;
    logic signed [1:0]     r_res_zoom, n_res_zoom;
    logic                  r_res_toggle, n_res_toggle;
    t_out_item             r_out, n_out;
    logic                  r_out_valid, n_out_valid;

    logic                  in_take;
    logic [OPER_W-1:0]     sq_a, sq_b;
    logic [2*OPER_W-1:0]   sq_out;
    logic                  sqrt_start, sqrt_done;
    logic [RAD_W-1:0]      radicand;
    logic [ROOT_W-1:0]     root;
    logic [EXT_W-1:0]      root_ext;
    logic [SPAN_W-1:0]     span, mag;
    logic [THR_W-1:0]      thr_sh;
    logic                  mag_ok;
    logic [TIME_BITS-1:0]  zoom_el, down_el, gap_el, tri_el;
    logic [1:0]            tally_base, tally_inc;

    assign in_take     = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall  = !i_rst_n || (r_state != S_IDLE);
    assign o_cfg_ready = i_rst_n;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign sqrt_start  = (r_state == S_ROOT_GO);
    assign radicand    = RAD_W'(r_acc[2*COORD_BITS:0]) << (2 * SPAN_FRAC_BITS);

    always_comb begin
        sq_a = '0;
        sq_b = '0;
        unique case (r_state)
            S_SQ_A: begin
                sq_a = r_pinch_path ? OPER_W'(r_x0) : OPER_W'(r_recent_x);
                sq_b = r_pinch_path ? OPER_W'(r_x1) : OPER_W'(r_down_x);
            end
            S_SQ_B: begin
                sq_a = r_pinch_path ? OPER_W'(r_y0) : OPER_W'(r_recent_y);
                sq_b = r_pinch_path ? OPER_W'(r_y1) : OPER_W'(r_down_y);
            end
            S_SQ_C: begin
                sq_a = r_move;
            end
            default: begin
                sq_a = '0;
            end
        endcase
    end

    pattr_sq u_sq (
        .i_clk (i_clk),
        .i_a   (sq_a),
        .i_b   (sq_b),
        .o_sq  (sq_out)
    );

    pattr_isqrt #(
        .RAD_W (RAD_W)
    ) u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sqrt_start),
        .i_radicand (radicand),
        .o_done     (sqrt_done),
        .o_root     (root)
    );

    always_comb begin
        root_ext   = EXT_W'(root);
        span       = (|root_ext[EXT_W-1:SPAN_W]) ? {SPAN_W{1'b1}} : root_ext[SPAN_W-1:0];
        mag        = (span >= r_prior_span) ? (span - r_prior_span) : (r_prior_span - span);
        thr_sh     = THR_W'(r_thr) << SPAN_FRAC_BITS;
        mag_ok     = (CMP_W'(mag) >= CMP_W'(thr_sh));
        zoom_el    = r_now - r_zoom_time;
        down_el    = r_now - r_down_time;
        gap_el     = r_now - r_tap_time;
        tri_el     = r_now - r_triple_time;
        tally_base = ((r_tap_tally != 2'd0) && (gap_el > TIME_BITS'(r_gap_max))) ?
                     2'd0 : r_tap_tally;
        tally_inc  = tally_base + 2'd1;
    end

    always_comb begin
        n_state        = r_state;
        n_pinch_active = r_pinch_active;
        n_prior_span   = r_prior_span;
        n_zoom_time    = r_zoom_time;
        n_finger_down  = r_finger_down;
        n_down_time    = r_down_time;
        n_down_x       = r_down_x;
        n_down_y       = r_down_y;
        n_recent_x     = r_recent_x;
        n_recent_y     = r_recent_y;
        n_tap_tally    = r_tap_tally;
        n_tap_time     = r_tap_time;
        n_triple_time  = r_triple_time;
        n_pinch_path   = r_pinch_path;
        n_acc          = r_acc;
        n_res_zoom     = r_res_zoom;
        n_res_toggle   = r_res_toggle;
        n_out          = r_out;
        n_out_valid    = r_out_valid && i_out_stall;

        unique case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_res_zoom   = ZOOM_NONE;
                n_res_toggle = 1'b0;
                n_state      = S_PUSH;
                if (!r_ok) begin
                    n_pinch_active = 1'b0;
                    n_prior_span   = '0;
                end else if (r_fresh) begin
                    if (r_cnt >= 4'd2) begin
                        n_finger_down = 1'b0;
                        n_tap_tally   = 2'd0;
                        n_pinch_path  = 1'b1;
                        n_state       = S_SQ_A;
                    end else begin
                        n_pinch_active = 1'b0;
                        n_prior_span   = '0;
                        if (r_cnt == 4'd1) begin
                            if (!r_finger_down) begin
                                n_finger_down = 1'b1;
                                n_down_time   = r_now;
                                n_down_x      = r_x0;
                                n_down_y      = r_y0;
                            end
                            n_recent_x = r_x0;
                            n_recent_y = r_y0;
                        end else if (r_finger_down) begin
                            n_finger_down = 1'b0;
                            if (down_el <= TIME_BITS'(r_tap_max)) begin
                                n_pinch_path = 1'b0;
                                n_state      = S_SQ_A;
                            end
                        end
                    end
                end
            end
            S_SQ_A: begin
                n_state = S_SQ_B;
            end
            S_SQ_B: begin
                n_state = S_SQ_C;
            end
            S_SQ_C: begin
                n_acc   = ACC_W'(sq_out);
                n_state = S_SQ_D;
            end
            S_SQ_D: begin
                n_acc   = r_acc + ACC_W'(sq_out);
                n_state = r_pinch_path ? S_ROOT_GO : S_TAP;
            end
            S_ROOT_GO: begin
                n_state = S_ROOT;
            end
            S_ROOT: begin
                if (sqrt_done) begin
                    n_state = S_PINCH;
                end
            end
            S_PINCH: begin
                n_prior_span = span;
                if (!r_pinch_active) begin
                    n_pinch_active = 1'b1;
                end else if ((zoom_el >= TIME_BITS'(r_zoom_cd)) && mag_ok) begin
                    n_zoom_time = r_now;
                    n_res_zoom  = (span > r_prior_span) ? ZOOM_IN : ZOOM_OUT;
                end
                n_state = S_PUSH;
            end
            S_TAP: begin
                if (r_acc <= ACC_W'(sq_out)) begin
                    n_tap_time  = r_now;
                    n_tap_tally = tally_inc;
                    if (tally_inc >= TAPS_FOR_TOGGLE) begin
                        n_tap_tally = 2'd0;
                        if (tri_el >= TIME_BITS'(r_tri_cd)) begin
                            n_triple_time = r_now;
                            n_res_toggle  = 1'b1;
                        end
                    end
                end
                n_state = S_PUSH;
            end
            S_PUSH: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out.zoom_step   = r_res_zoom;
                    n_out.mode_toggle = r_res_toggle;
                    n_out_valid       = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_thr          <= RST_PINCH_THR;
            r_zoom_cd      <= RST_PINCH_CD;
            r_tap_max      <= RST_TAP_MAX;
            r_gap_max      <= RST_INTER_TAP;
            r_tri_cd       <= RST_TRIPLE_CD;
            r_move         <= RST_TAP_MOVE;
            r_pinch_active <= 1'b0;
            r_prior_span   <= '0;
            r_zoom_time    <= '0;
            r_finger_down  <= 1'b0;
            r_down_time    <= '0;
            r_down_x       <= '0;
            r_down_y       <= '0;
            r_recent_x     <= '0;
            r_recent_y     <= '0;
            r_tap_tally    <= 2'd0;
            r_tap_time     <= '0;
            r_triple_time  <= '0;
            r_pinch_path   <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_pinch_active <= n_pinch_active;
            r_prior_span   <= n_prior_span;
            r_zoom_time    <= n_zoom_time;
            r_finger_down  <= n_finger_down;
            r_down_time    <= n_down_time;
            r_down_x       <= n_down_x;
            r_down_y       <= n_down_y;
            r_recent_x     <= n_recent_x;
            r_recent_y     <= n_recent_y;
            r_tap_tally    <= n_tap_tally;
            r_tap_time     <= n_tap_time;
            r_triple_time  <= n_triple_time;
            r_pinch_path   <= n_pinch_path;
            r_out_valid    <= n_out_valid;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_PINCH_THR: r_thr     <= i_cfg_data;
                    CFG_PINCH_CD:  r_zoom_cd <= i_cfg_data;
                    CFG_TAP_MAX:   r_tap_max <= i_cfg_data;
                    CFG_INTER_TAP: r_gap_max <= i_cfg_data;
                    CFG_TRIPLE_CD: r_tri_cd  <= i_cfg_data;
                    CFG_TAP_MOVE:  r_move    <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
        r_acc        <= n_acc;
        r_res_zoom   <= n_res_zoom;
        r_res_toggle <= n_res_toggle;
        r_out        <= n_out;
        if (in_take) begin
            r_ok    <= i_in_data.frame_ok;
            r_fresh <= i_in_data.new_data;
            r_cnt   <= i_in_data.touch_count;
            r_x0    <= i_in_data.first_x[COORD_BITS-1:0];
            r_y0    <= i_in_data.first_y[COORD_BITS-1:0];
            r_x1    <= i_in_data.second_x[COORD_BITS-1:0];
            r_y1    <= i_in_data.second_y[COORD_BITS-1:0];
            r_now   <= i_in_data.now_ms[TIME_BITS-1:0];
        end
    end

    a_one_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.mode_toggle && (o_out_data.zoom_step != ZOOM_NONE)))
        else $error("zoom step and mode toggle in one result");

    a_zoom_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.zoom_step != 2'sb10))
        else $error("illegal zoom step code");

    a_tally_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tap_tally != TAPS_FOR_TOGGLE)
        else $error("tap tally reached toggle count");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request taken while previous one in progress");

    a_root_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sqrt_done |-> (r_state == S_ROOT))
        else $error("square root finished outside its wait state");

endmodule : pinch_and_triple_tap_recognizer
`default_nettype wire

>>> hdl/pattr_sq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pattr_sq
// Shared two-stage unit: absolute difference, then square.
// ----------------------------------------------------------------------------
module pattr_sq (
    input  wire logic                          i_clk,
    input  wire logic [pattr_pkg::OPER_W-1:0]   i_a,
    input  wire logic [pattr_pkg::OPER_W-1:0]   i_b,
    output logic      [2*pattr_pkg::OPER_W-1:0] o_sq
);
    import pattr_pkg::*;

    logic [OPER_W-1:0]   r_diff;
    logic [2*OPER_W-1:0] r_sq;

    always_ff @(posedge i_clk) begin
        r_diff <= (i_a > i_b) ? (i_a - i_b) : (i_b - i_a);
        r_sq   <= r_diff * r_diff;
    end

    assign o_sq = r_sq;

endmodule : pattr_sq
`default_nettype wire

>>> hdl/pattr_isqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pattr_isqrt
// Integer square root, restoring method, one root bit per cycle.
// ----------------------------------------------------------------------------
module pattr_isqrt #(
    parameter int RAD_W = 41
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [RAD_W-1:0]           i_radicand,
    output logic                            o_done,
    output logic      [(RAD_W+1)/2-1:0]     o_root
);
    localparam int ROOT_W = (RAD_W + 1) / 2;
    localparam int PAD_W  = 2 * ROOT_W;
    localparam int CNT_W  = $clog2(ROOT_W + 1);

    logic [PAD_W-1:0]  r_rad;
    logic [ROOT_W:0]   r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_done;

    logic [ROOT_W+2:0] rem_sh;
    logic [ROOT_W+2:0] trial;
    logic [ROOT_W+2:0] rem_dif;
    logic              take;

    always_comb begin
        rem_sh  = {r_rem, r_rad[PAD_W-1 -: 2]};
        trial   = (ROOT_W+3)'({r_root, 2'b01});
        take    = (rem_sh >= trial);
        rem_dif = take ? (rem_sh - trial) : rem_sh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rad  <= PAD_W'(i_radicand);
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= CNT_W'(ROOT_W);
            end else if (r_cnt != '0) begin
                r_rad  <= r_rad << 2;
                r_rem  <= rem_dif[ROOT_W:0];
                r_root <= {r_root[ROOT_W-2:0], take};
                r_cnt  <= r_cnt - CNT_W'(1);
                r_done <= (r_cnt == CNT_W'(1));
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule : pattr_isqrt
`default_nettype wire

>>> dv/pinch_and_triple_tap_recognizer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pinch_and_triple_tap_recognizer_tb
// Drives decoded touch frames into the recognizer and predicts the zoom step
// and mode toggle of every accepted request. Predictions are queued in a
// scoreboard and compared in order with each accepted result. A short directed
// sequence is followed by phases of random tap and pinch gestures under varied
// register settings, sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module pinch_and_triple_tap_recognizer_tb;
    import pattr_pkg::*;

    localparam int HALF_PERIOD      = 5;
    localparam int SPAN_FRAC        = 4;
    localparam int N_REGS           = 6;
    localparam int N_PHASES         = 6;
    localparam int FRAMES_PER_PHASE = 100;
    localparam int LONG_HOLD        = 400;
    localparam int SETTLE_CYCLES    = 40;
    localparam int TIMEOUT_NS       = 5_000_000;
    localparam logic [SPAN_W-1:0] SPAN_SAT = '1;

    class gesture_scoreboard;
        logic [CFG_DATA_W-1:0] regs [N_REGS];
        bit                    pinch_active;
        logic [SPAN_W-1:0]     prior_span;
        logic [31:0]           zoom_time;
        bit                    finger_down;
        logic [31:0]           down_time;
        logic [15:0]           down_x;
        logic [15:0]           down_y;
        logic [15:0]           recent_x;
        logic [15:0]           recent_y;
        logic [1:0]            tap_tally;
        logic [31:0]           tap_time;
        logic [31:0]           triple_time;
        t_out_item             expected_results [$];
        int unsigned           n_errors;

        function new();
            regs[CFG_PINCH_THR] = RST_PINCH_THR;
            regs[CFG_PINCH_CD]  = RST_PINCH_CD;
            regs[CFG_TAP_MAX]   = RST_TAP_MAX;
            regs[CFG_INTER_TAP] = RST_INTER_TAP;
            regs[CFG_TRIPLE_CD] = RST_TRIPLE_CD;
            regs[CFG_TAP_MOVE]  = RST_TAP_MOVE;
            pinch_active = 1'b0;
            prior_span   = '0;
            zoom_time    = '0;
            finger_down  = 1'b0;
            down_time    = '0;
            down_x       = '0;
            down_y       = '0;
            recent_x     = '0;
            recent_y     = '0;
            tap_tally    = '0;
            tap_time     = '0;
            triple_time  = '0;
            n_errors     = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx < N_REGS) begin
                regs[idx] = val;
            end
        endfunction

        function logic [63:0] int_sqrt(logic [63:0] v);
            logic [63:0] root;
            logic [63:0] bit_w;
            root  = '0;
            bit_w = 64'd1 << 62;
            while (bit_w > v) bit_w >>= 2;
            while (bit_w != 0) begin
                if (v >= root + bit_w) begin
                    v    = v - (root + bit_w);
                    root = (root >> 1) + bit_w;
                end else begin
                    root >>= 1;
                end
                bit_w >>= 2;
            end
            return root;
        endfunction

        function logic [63:0] sq_dist(logic [15:0] ax, logic [15:0] ay,
                                      logic [15:0] bx, logic [15:0] by);
            logic [63:0] dx;
            logic [63:0] dy;
            dx = (ax > bx) ? 64'(ax - bx) : 64'(bx - ax);
            dy = (ay > by) ? 64'(ay - by) : 64'(by - ay);
            return dx * dx + dy * dy;
        endfunction

        function logic [31:0] ms_since(logic [31:0] now, logic [31:0] past);
            return now - past;
        endfunction

        function t_out_item predict_gesture(t_in_item f);
            t_out_item                r;
            logic [63:0]              span_full;
            logic [SPAN_W-1:0]        span;
            logic signed [SPAN_W+1:0] delta;
            logic [SPAN_W+1:0]        mag;
            logic [31:0]              thr;
            logic [63:0]              move_sq;
            r.zoom_step   = ZOOM_NONE;
            r.mode_toggle = 1'b0;
            if (!f.frame_ok) begin
                pinch_active = 1'b0;
                prior_span   = '0;
                return r;
            end
            if (!f.new_data) return r;

            if (f.touch_count >= 2) begin
                finger_down = 1'b0;
                tap_tally   = '0;
                span_full = int_sqrt(sq_dist(f.first_x, f.first_y, f.second_x, f.second_y)
                                     << (2 * SPAN_FRAC));
                span = (span_full > SPAN_SAT) ? SPAN_SAT : span_full[SPAN_W-1:0];
                if (!pinch_active) begin
                    pinch_active = 1'b1;
                    prior_span   = span;
                    return r;
                end
                delta = $signed({2'b00, span}) - $signed({2'b00, prior_span});
                prior_span = span;
                if (ms_since(f.now_ms, zoom_time) < regs[CFG_PINCH_CD]) return r;
                mag = (delta < 0) ? -delta : delta;
                thr = 32'(regs[CFG_PINCH_THR]) << SPAN_FRAC;
                if (mag < thr) return r;
                zoom_time   = f.now_ms;
                r.zoom_step = (delta > 0) ? ZOOM_IN : ZOOM_OUT;
                return r;
            end

            pinch_active = 1'b0;
            prior_span   = '0;

            if (f.touch_count == 1) begin
                if (!finger_down) begin
                    finger_down = 1'b1;
                    down_time   = f.now_ms;
                    down_x      = f.first_x;
                    down_y      = f.first_y;
                end
                recent_x = f.first_x;
                recent_y = f.first_y;
                return r;
            end

            if (!finger_down) return r;
            finger_down = 1'b0;
            if (ms_since(f.now_ms, down_time) > regs[CFG_TAP_MAX]) return r;
            move_sq = 64'(regs[CFG_TAP_MOVE]) * 64'(regs[CFG_TAP_MOVE]);
            if (sq_dist(recent_x, recent_y, down_x, down_y) > move_sq) return r;

            if (tap_tally > 0 && ms_since(f.now_ms, tap_time) > regs[CFG_INTER_TAP]) begin
                tap_tally = '0;
            end
            tap_tally = tap_tally + 2'd1;
            tap_time  = f.now_ms;
            if (tap_tally >= TAPS_FOR_TOGGLE) begin
                tap_tally = '0;
                if (ms_since(f.now_ms, triple_time) >= regs[CFG_TRIPLE_CD]) begin
                    triple_time   = f.now_ms;
                    r.mode_toggle = 1'b1;
                end
            end
            return r;
        endfunction

        function void note_frame(t_in_item f);
            expected_results.push_back(predict_gesture(f));
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (expected_results.size() == 0) begin
                $error("result with no pending request: zoom_step %0d mode_toggle %0d",
                       got.zoom_step, got.mode_toggle);
                n_errors++;
                return;
            end
            want = expected_results.pop_front();
            if (got.zoom_step !== want.zoom_step) begin
                $error("zoom_step: expected %0d, actual %0d", want.zoom_step, got.zoom_step);
                n_errors++;
            end
            if (got.mode_toggle !== want.mode_toggle) begin
                $error("mode_toggle: expected %0d, actual %0d",
                       want.mode_toggle, got.mode_toggle);
                n_errors++;
            end
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    t_in_item              in_data   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_out_item             out_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    logic                  hold_tgl  = 1'b0;
    int                    stall_pct = 0;
    int                    idle_pct  = 0;
    int                    frames_sent = 0;
    logic [31:0]           ms_now = '0;
    gesture_scoreboard     sb;

    always #HALF_PERIOD clk = ~clk;

    pinch_and_triple_tap_recognizer u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && !in_stall) sb.note_frame(in_data);
            if (out_valid && !out_stall) sb.check_result(out_data);
        end
    end

    // receiver: random stalls plus one long hold-off per toggle of hold_tgl
    initial begin : receiver
        int   hold_left;
        logic hold_seen;
        hold_left = 0;
        hold_seen = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_tgl != hold_seen) begin
                hold_seen = hold_tgl;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= ($urandom_range(99, 0) < stall_pct);
            end
        end
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic logic [15:0] rand_px();
        return 16'($urandom);
    endfunction

    function automatic logic [15:0] clamp_px(int v);
        if (v < 0) return 16'h0000;
        if (v > 65535) return 16'hFFFF;
        return 16'(v);
    endfunction

    function automatic logic [15:0] nudge(logic [15:0] c, int spread);
        return clamp_px(int'(c) + int'($urandom_range(0, 2 * spread)) - spread);
    endfunction

    function automatic t_in_item make_frame(bit ok, bit fresh, logic [3:0] fingers,
                                            logic [15:0] ax, logic [15:0] ay,
                                            logic [15:0] bx, logic [15:0] by,
                                            logic [31:0] stamp);
        t_in_item f;
        f.frame_ok    = ok;
        f.new_data    = fresh;
        f.touch_count = fingers;
        f.first_x     = ax;
        f.first_y     = ay;
        f.second_x    = bx;
        f.second_y    = by;
        f.now_ms      = stamp;
        return f;
    endfunction

    task automatic send_frame(input t_in_item f);
        while ($urandom_range(99, 0) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= f;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if (!f.frame_ok || f.new_data) frames_sent++;
    endtask

    task automatic write_reg_set(input logic [CFG_DATA_W-1:0] vals [N_REGS], input bit stray);
        int last;
        last = stray ? (1 << CFG_IDX_W) - 1 : N_REGS - 1;
        for (int k = 0; k <= last; k++) begin
            cfg_valid <= 1'b1;
            cfg_index <= CFG_IDX_W'(k);
            cfg_data  <= (k < N_REGS) ? vals[k] : 16'($urandom);
            @(posedge clk);
            while (!cfg_ready) @(posedge clk);
            sb.write_reg(cfg_index, cfg_data);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic play_gestures(input int n_frames);
        int          start;
        int          pick;
        int          n_taps;
        int          n_down;
        int          hold;
        int          spread;
        int          step_lim;
        int          sep_x;
        int          sep_y;
        logic [15:0] base_x;
        logic [15:0] base_y;
        start = frames_sent;
        while (frames_sent - start < n_frames) begin
            pick   = $urandom_range(99, 0);
            base_x = rand_px();
            base_y = rand_px();
            if (pick < 45) begin
                n_taps = $urandom_range(1, 4);
                spread = $urandom_range(0, sb.regs[CFG_TAP_MOVE]) + 1;
                repeat (n_taps) begin
                    ms_now += $urandom_range(0, sb.regs[CFG_INTER_TAP] * 5 / 4 + 1);
                    hold   = $urandom_range(0, sb.regs[CFG_TAP_MAX] * 5 / 4 + 1);
                    n_down = $urandom_range(1, 3);
                    for (int k = 0; k < n_down; k++) begin
                        send_frame(make_frame(1'b1, 1'b1, 4'd1, nudge(base_x, spread),
                                              nudge(base_y, spread), rand_px(), rand_px(),
                                              ms_now + 32'(hold * k / n_down)));
                    end
                    ms_now += 32'(hold);
                    send_frame(make_frame(1'b1, 1'b1, 4'd0, rand_px(), rand_px(),
                                          rand_px(), rand_px(), ms_now));
                end
            end else if (pick < 80) begin
                step_lim = sb.regs[CFG_PINCH_THR] * 3 / 2 + 4;
                sep_x    = int'($urandom_range(0, 4000)) - 2000;
                sep_y    = int'($urandom_range(0, 4000)) - 2000;
                repeat ($urandom_range(2, 6)) begin
                    sep_x  += int'($urandom_range(0, 2 * step_lim)) - step_lim;
                    sep_y  += int'($urandom_range(0, 2 * step_lim)) - step_lim;
                    ms_now += $urandom_range(0, sb.regs[CFG_PINCH_CD] * 3 / 2 + 1);
                    send_frame(make_frame(1'b1, 1'b1, 4'($urandom_range(2, 15)), base_x, base_y,
                                          clamp_px(int'(base_x) + sep_x),
                                          clamp_px(int'(base_y) + sep_y), ms_now));
                end
            end else begin
                ms_now += $urandom_range(0, 500);
                send_frame(make_frame($urandom_range(0, 3) != 0, $urandom_range(0, 3) != 0,
                                      4'($urandom_range(0, 15)), rand_px(), rand_px(),
                                      rand_px(), rand_px(),
                                      ($urandom_range(0, 9) == 0) ? $urandom : ms_now));
            end
        end
        in_valid <= 1'b0;
    endtask

    initial begin : main
        logic [CFG_DATA_W-1:0] phase_cfg [N_REGS];
        int idle_by_phase  [N_PHASES];
        int stall_by_phase [N_PHASES];
        idle_by_phase  = '{0, 79, 0, 6, 0, 79};
        stall_by_phase = '{0, 0, 79, 6, 0, 79};
        sb = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset settings, timers start at zero
        send_frame(make_frame(1'b1, 1'b1, 4'd2, 16'd0, 16'd0, 16'd100, 16'd0, 32'd0));
        send_frame(make_frame(1'b1, 1'b1, 4'd2, 16'd0, 16'd0, 16'd300, 16'd0, 32'd100));
        send_frame(make_frame(1'b1, 1'b1, 4'd15, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 32'd700));
        send_frame(make_frame(1'b1, 1'b1, 4'd2, 16'd0, 16'd0, 16'd0, 16'd10, 32'd1400));
        send_frame(make_frame(1'b0, 1'b1, 4'd2, rand_px(), rand_px(), rand_px(), rand_px(),
                              32'd1500));
        send_frame(make_frame(1'b1, 1'b0, 4'd2, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 32'd1600));
        send_frame(make_frame(1'b1, 1'b1, 4'd2, 16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 32'd1700));
        // three taps then a toggle, then three more inside the triple cooldown
        send_frame(make_frame(1'b1, 1'b1, 4'd1, 16'd100, 16'd100, 16'd0, 16'd0, 32'd3000));
        send_frame(make_frame(1'b1, 1'b1, 4'd0, 16'd0, 16'd0, 16'd0, 16'd0, 32'd3100));
        send_frame(make_frame(1'b1, 1'b1, 4'd1, 16'd120, 16'd90, 16'd0, 16'd0, 32'd3200));
        send_frame(make_frame(1'b1, 1'b1, 4'd0, 16'd0, 16'd0, 16'd0, 16'd0, 32'd3300));
        send_frame(make_frame(1'b1, 1'b1, 4'd1, 16'd100, 16'd100, 16'd0, 16'd0, 32'd3400));
        send_frame(make_frame(1'b1, 1'b1, 4'd0, 16'd0, 16'd0, 16'd0, 16'd0, 32'd3500));
        send_frame(make_frame(1'b1, 1'b1, 4'd1, 16'd100, 16'd100, 16'd0, 16'd0, 32'd3550));
        send_frame(make_frame(1'b1, 1'b1, 4'd0, 16'd0, 16'd0, 16'd0, 16'd0, 32'd3600));
        send_frame(make_frame(1'b1, 1'b1, 4'd1, 16'd100, 16'd100, 16'd0, 16'd0, 32'd3650));
        send_frame(make_frame(1'b1, 1'b1, 4'd0, 16'd0, 16'd0, 16'd0, 16'd0, 32'd3700));
        send_frame(make_frame(1'b1, 1'b1, 4'd1, 16'd100, 16'd100, 16'd0, 16'd0, 32'd3750));
        send_frame(make_frame(1'b1, 1'b1, 4'd0, 16'd0, 16'd0, 16'd0, 16'd0, 32'd3800));
        // held too long
        send_frame(make_frame(1'b1, 1'b1, 4'd1, 16'd100, 16'd100, 16'd0, 16'd0, 32'd5000));
        send_frame(make_frame(1'b1, 1'b1, 4'd0, 16'd0, 16'd0, 16'd0, 16'd0, 32'd5500));
        // two fingers drop the tally, then a tap restarts it; the last press is held too long
        send_frame(make_frame(1'b1, 1'b1, 4'd1, 16'd100, 16'd100, 16'd0, 16'd0, 32'd6000));
        send_frame(make_frame(1'b1, 1'b1, 4'd0, 16'd0, 16'd0, 16'd0, 16'd0, 32'd6100));
        send_frame(make_frame(1'b1, 1'b1, 4'd3, rand_px(), rand_px(), rand_px(), rand_px(),
                              32'd6200));
        send_frame(make_frame(1'b1, 1'b1, 4'd1, 16'd100, 16'd100, 16'd0, 16'd0, 32'd6300));
        send_frame(make_frame(1'b1, 1'b1, 4'd0, 16'd0, 16'd0, 16'd0, 16'd0, 32'd6350));
        send_frame(make_frame(1'b1, 1'b1, 4'd1, 16'd100, 16'd100, 16'd0, 16'd0, 32'd7500));
        send_frame(make_frame(1'b1, 1'b1, 4'd0, 16'd0, 16'd0, 16'd0, 16'd0, 32'hFFFF_FFFF));
        in_valid <= 1'b0;
        drain();

        for (int p = 0; p < N_PHASES; p++) begin
            for (int k = 0; k < N_REGS; k++) begin
                case (p)
                    2:       phase_cfg[k] = '0;
                    3:       phase_cfg[k] = '1;
                    default: phase_cfg[k] = ($urandom_range(0, 1) != 0)
                                            ? 16'($urandom_range(0, 120))
                                            : 16'($urandom_range(0, 1500));
                endcase
            end
            if (p == 4) begin
                phase_cfg[CFG_PINCH_THR] = RST_PINCH_THR;
                phase_cfg[CFG_PINCH_CD]  = RST_PINCH_CD;
                phase_cfg[CFG_TAP_MAX]   = RST_TAP_MAX;
                phase_cfg[CFG_INTER_TAP] = RST_INTER_TAP;
                phase_cfg[CFG_TRIPLE_CD] = RST_TRIPLE_CD;
                phase_cfg[CFG_TAP_MOVE]  = RST_TAP_MOVE;
            end
            write_reg_set(phase_cfg, p == 0);
            ms_now    = (p == 3) ? 32'hFFFF_F000 : $urandom;
            idle_pct  = idle_by_phase[p];
            stall_pct <= stall_by_phase[p];
            if (p == 4) hold_tgl <= ~hold_tgl;
            play_gestures(FRAMES_PER_PHASE);
            drain();
        end

        if (sb.n_errors == 0 && sb.pending() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
